[rtl/tmlh_pkg.sv]
// Package for the twin-motor lift height controller.
// Holds the state, command, event and register codes, constants and duty helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmlh_pkg;

  localparam int unsigned SensorBitsDefault = 10;
  localparam int unsigned TimeBitsDefault   = 32;

  localparam logic [9:0] HEIGHT_BASE_MM = 10'd670;
  localparam logic [7:0] HEIGHT_SCALE   = 8'd250;
  localparam logic [9:0] CHECK_DELAY_MS = 10'd1000;
  localparam int         STALL_UP_MM    = 10;
  localparam int         STALL_DOWN_MM  = 2;

  localparam logic [7:0] UP_ONE_RST   = 8'd220;
  localparam logic [7:0] UP_TWO_RST   = 8'd200;
  localparam logic [7:0] DOWN_ONE_RST = 8'd220;
  localparam logic [7:0] DOWN_TWO_RST = 8'd180;

  localparam logic [7:0]  ROLL_THR_RST    = 8'd4;
  localparam logic [7:0]  SPEED_MAX_RST   = 8'd230;
  localparam logic [7:0]  SPEED_MIN_RST   = 8'd150;
  localparam logic [3:0]  SPEED_STEP_RST  = 4'd3;
  localparam logic [15:0] TIMEOUT_RST     = 16'd5000;
  localparam logic [15:0] INTERVAL_RST    = 16'd500;
  localparam logic [9:0]  HEIGHT_MIN_RST  = 10'd600;
  localparam logic [9:0]  HEIGHT_MAX_RST  = 10'd930;

  typedef enum logic [1:0] {
    ST_STOP = 2'd0,
    ST_UP   = 2'd1,
    ST_DOWN = 2'd2
  } motion_e;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_STOP = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_RANGE    = 3'd1,
    EV_HEIGHT   = 3'd2,
    EV_REACHED  = 3'd3,
    EV_TIMEOUT  = 3'd4,
    EV_STALLED  = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    REG_ROLL_THR   = 3'd0,
    REG_SPEED_MAX  = 3'd1,
    REG_SPEED_MIN  = 3'd2,
    REG_SPEED_STEP = 3'd3,
    REG_TIMEOUT    = 3'd4,
    REG_INTERVAL   = 3'd5,
    REG_HEIGHT_MIN = 3'd6,
    REG_HEIGHT_MAX = 3'd7
  } cfg_reg_e;

  // Raise below the ceiling, saturate at full scale.
  function automatic logic [7:0] raise_duty(logic [7:0] d, logic [7:0] lim, logic [3:0] step);
    logic [8:0] sum;
    sum = {1'b0, d} + {5'd0, step};
    if (d < lim) begin
      raise_duty = sum[8] ? 8'hFF : sum[7:0];
    end else begin
      raise_duty = d;
    end
  endfunction

  // Lower above the floor, saturate at zero.
  function automatic logic [7:0] lower_duty(logic [7:0] d, logic [7:0] lim, logic [3:0] step);
    if (d > lim) begin
      lower_duty = (d > {4'd0, step}) ? (d - {4'd0, step}) : 8'd0;
    end else begin
      lower_duty = d;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/twin_motor_lift_height_controller_top.sv]
// Twin-motor lift height controller, top level.
// Two-register pipeline: input word register, single-pass control logic, result register.
// Depends on tmlh_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Every input word yields exactly one result word; it moves from the input register into
// the result register. A new word is accepted every clock while the result side does not
// stall: the control step (height conversion, duty rebalance, stall and end checks) is one
// pass of logic between the input register and the result register, and the lift state
// updates as the word moves into the result register. Backpressure on the result side
// holds the input register and then drops s_axis_tready_o. Configuration writes are taken
// every cycle and apply to words processed after them.
module twin_motor_lift_height_controller_top
  import tmlh_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = SensorBitsDefault,
  parameter int unsigned TIME_BITS   = TimeBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // target_height_mm[9:0], height_raw[19:10], roll[32:20], now_ms[64:33], zero[71:65]
  input  wire logic [71:0] s_axis_tdata_i,
  // cmd[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // pwm_left[7:0], pwm_right[15:8], direction_down[16], power_on[17],
  // move_status[19:18], height_mm[29:20], event_res[32:30], zero[39:33]
  output logic [39:0]      m_axis_tdata_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned SB = SENSOR_BITS;
  localparam int unsigned TB = TIME_BITS;

  // configuration
  logic [7:0]  roll_thr_q, speed_max_q, speed_min_q;
  logic [3:0]  speed_step_q;
  logic [15:0] timeout_q, interval_q;
  logic [9:0]  height_min_q, height_max_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_thr_q   <= ROLL_THR_RST;
      speed_max_q  <= SPEED_MAX_RST;
      speed_min_q  <= SPEED_MIN_RST;
      speed_step_q <= SPEED_STEP_RST;
      timeout_q    <= TIMEOUT_RST;
      interval_q   <= INTERVAL_RST;
      height_min_q <= HEIGHT_MIN_RST;
      height_max_q <= HEIGHT_MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROLL_THR:   roll_thr_q   <= cfg_data_i[7:0];
        REG_SPEED_MAX:  speed_max_q  <= cfg_data_i[7:0];
        REG_SPEED_MIN:  speed_min_q  <= cfg_data_i[7:0];
        REG_SPEED_STEP: speed_step_q <= cfg_data_i[3:0];
        REG_TIMEOUT:    timeout_q    <= cfg_data_i;
        REG_INTERVAL:   interval_q   <= cfg_data_i;
        REG_HEIGHT_MIN: height_min_q <= cfg_data_i[9:0];
        REG_HEIGHT_MAX: height_max_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // input word register
  logic                 in_valid_q;
  cmd_e                 in_cmd_q;
  logic [9:0]           in_target_q;
  logic [SB-1:0]        in_raw_q;
  logic signed [12:0]   in_roll_q;
  logic [TB-1:0]        in_now_q;
  logic                 out_valid_q;
  logic                 advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q    <= cmd_e'(s_axis_tuser_i);
      in_target_q <= s_axis_tdata_i[9:0];
      in_raw_q    <= SB'(s_axis_tdata_i[19:10]);
      in_roll_q   <= s_axis_tdata_i[32:20];
      in_now_q    <= TB'(s_axis_tdata_i[64:33]);
    end
  end

  // lift state
  motion_e       state_q, state_d;
  logic [7:0]    up_one_q, up_two_q, down_one_q, down_two_q;
  logic [7:0]    up_one_d, up_two_d, down_one_d, down_two_d;
  logic [9:0]    present_q, present_d, previous_q, previous_d, goal_q, goal_d;
  logic [TB-1:0] start_q, start_d, check_q, check_d;
  event_e        event_d;

  // height conversion
  logic [SB+7:0] scaled;
  logic [9:0]    height_calc;
  assign scaled      = {8'd0, ~in_raw_q} * {{SB{1'b0}}, HEIGHT_SCALE};
  assign height_calc = HEIGHT_BASE_MM + {2'b00, scaled[SB+7:SB]};

  logic height_ok, target_ok;
  assign height_ok = (height_calc >= height_min_q) && (height_calc <= height_max_q);
  assign target_ok = (in_target_q >= height_min_q) && (in_target_q <= height_max_q);

  // roll compare
  logic signed [13:0] roll_w, thr_w, thr_n;
  logic               tilt_pos, tilt_neg;
  assign roll_w   = {in_roll_q[12], in_roll_q};
  assign thr_w    = $signed({6'd0, roll_thr_q});
  assign thr_n    = -thr_w;
  assign tilt_pos = roll_w > thr_w;
  assign tilt_neg = roll_w < thr_n;

  // timing and stall
  logic [TB-1:0]      elapsed, since_check;
  logic               check_due, timed_out;
  logic signed [10:0] delta;
  logic               stall_up, stall_down;
  assign elapsed     = in_now_q - start_q;
  assign since_check = in_now_q - check_q;
  assign check_due   = !since_check[TB-1] && (since_check > TB'(interval_q));
  assign timed_out   = elapsed >= TB'(timeout_q);
  assign delta       = $signed({1'b0, previous_q}) - $signed({1'b0, height_calc});
  assign stall_up    = (delta < 11'(STALL_UP_MM)) && (delta > -11'(STALL_UP_MM));
  assign stall_down  = delta < 11'(STALL_DOWN_MM);

  always_comb begin
    state_d    = state_q;
    up_one_d   = up_one_q;
    up_two_d   = up_two_q;
    down_one_d = down_one_q;
    down_two_d = down_two_q;
    present_d  = present_q;
    previous_d = previous_q;
    goal_d     = goal_q;
    start_d    = start_q;
    check_d    = check_q;
    event_d    = EV_NONE;
    case (in_cmd_q)
      CMD_MOVE: begin
        if (!target_ok) begin
          event_d = EV_RANGE;
        end else begin
          present_d = height_calc;
          if (!height_ok) begin
            event_d = EV_HEIGHT;
          end else begin
            goal_d     = in_target_q;
            previous_d = height_calc;
            start_d    = in_now_q;
            check_d    = in_now_q + TB'(CHECK_DELAY_MS);
            if (in_target_q > height_calc) begin
              state_d = ST_UP;
              if (timeout_q == '0) begin
                state_d = ST_STOP;
                event_d = EV_TIMEOUT;
              end
            end else if (in_target_q == height_calc) begin
              state_d = ST_STOP;
              event_d = EV_REACHED;
            end else begin
              state_d = ST_DOWN;
              if (timeout_q == '0) begin
                state_d = ST_STOP;
                event_d = EV_TIMEOUT;
              end
            end
          end
        end
      end
      CMD_STOP: begin
        state_d = ST_STOP;
      end
      CMD_TICK: begin
        if (state_q != ST_STOP) begin
          if (state_q == ST_UP) begin
            if (tilt_pos) begin
              up_two_d = raise_duty(up_two_q, speed_max_q, speed_step_q);
              up_one_d = lower_duty(up_one_q, speed_min_q, speed_step_q);
            end else if (tilt_neg) begin
              up_one_d = raise_duty(up_one_q, speed_max_q, speed_step_q);
              up_two_d = lower_duty(up_two_q, speed_min_q, speed_step_q);
            end
          end else begin
            if (tilt_pos) begin
              down_one_d = raise_duty(down_one_q, speed_max_q, speed_step_q);
              down_two_d = lower_duty(down_two_q, speed_min_q, speed_step_q);
            end else if (tilt_neg) begin
              down_two_d = raise_duty(down_two_q, speed_max_q, speed_step_q);
              down_one_d = lower_duty(down_one_q, speed_min_q, speed_step_q);
            end
          end
          present_d = height_calc;
          if (check_due) begin
            previous_d = height_calc;
            check_d    = in_now_q;
          end
          if (check_due && ((state_q == ST_UP) ? stall_up : stall_down)) begin
            state_d = ST_STOP;
            event_d = EV_STALLED;
          end else if ((state_q == ST_UP) ? (height_calc >= goal_q)
                                          : (height_calc <= goal_q)) begin
            state_d = ST_STOP;
            event_d = EV_REACHED;
          end else if (timed_out) begin
            state_d = ST_STOP;
            event_d = EV_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_STOP;
      up_one_q   <= UP_ONE_RST;
      up_two_q   <= UP_TWO_RST;
      down_one_q <= DOWN_ONE_RST;
      down_two_q <= DOWN_TWO_RST;
      present_q  <= '0;
      previous_q <= '0;
      goal_q     <= '0;
      start_q    <= '0;
      check_q    <= '0;
    end else if (advance) begin
      state_q    <= state_d;
      up_one_q   <= up_one_d;
      up_two_q   <= up_two_d;
      down_one_q <= down_one_d;
      down_two_q <= down_two_d;
      present_q  <= present_d;
      previous_q <= previous_d;
      goal_q     <= goal_d;
      start_q    <= start_d;
      check_q    <= check_d;
    end
  end

  // result register
  logic [7:0] pwm_l_d, pwm_r_d, pwm_l_q, pwm_r_q;
  motion_e    status_q;
  logic [9:0] height_q;
  event_e     event_q;

  always_comb begin
    case (state_d)
      ST_UP: begin
        pwm_l_d = up_one_d;
        pwm_r_d = up_two_d;
      end
      ST_DOWN: begin
        pwm_l_d = down_one_d;
        pwm_r_d = down_two_d;
      end
      default: begin
        pwm_l_d = 8'd0;
        pwm_r_d = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pwm_l_q  <= pwm_l_d;
      pwm_r_q  <= pwm_r_d;
      status_q <= state_d;
      height_q <= present_d;
      event_q  <= event_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, event_q, height_q, status_q,
                            (status_q != ST_STOP), (status_q == ST_DOWN),
                            pwm_r_q, pwm_l_q};

  a_stop_pwm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_STOP) |-> (pwm_l_q == 8'd0) && (pwm_r_q == 8'd0))
    else $error("stopped result with nonzero duty");

  a_end_event_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (event_q == EV_REACHED || event_q == EV_TIMEOUT ||
                    event_q == EV_STALLED) |-> (status_q == ST_STOP))
    else $error("end event while still moving");

  a_ready_low_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without result backpressure");

endmodule

`default_nettype wire
